// File: hdl/c3lr_pkg.sv
// Shared types and constants for the 3x3 convolution layer with leaky ReLU.
package c3lr_pkg;

  localparam int KERNEL_SIZE_DEF    = 3;
  localparam int MAX_IN_PLANES_DEF  = 32;
  localparam int MAX_OUT_PLANES_DEF = 32;
  localparam int MAX_DIM_DEF        = 64;

  localparam int SLOPE_MUL   = 6554;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int VALUE_W     = 16;

  typedef enum logic [1:0] {
    KIND_WEIGHT  = 2'd0,
    KIND_BIAS    = 2'd1,
    KIND_PIXEL   = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_NIN    = 2'd2,
    CFG_NOUT   = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_ACT   = 4'b1000
  } state_e;

  typedef struct packed {
    logic wgt_we;
    logic bias_we;
    logic pix_we;
    logic bias_re;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic init;
    logic mul_en;
    logic acc_en;
    logic fin_en;
  } mac_ctl_t;

endpackage

// File: hdl/c3lr_if.sv
// Valid/ready channel interfaces for input items and result items.
interface c3lr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [4:0]        out_plane;
  logic [4:0]        in_plane;
  logic [5:0]        row;
  logic [5:0]        col;
  logic signed [15:0] value;
  modport source (output valid, kind, out_plane, in_plane, row, col, value, input ready);
  modport sink (input valid, kind, out_plane, in_plane, row, col, value, output ready);
endinterface

interface c3lr_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] out_value;
  logic              saturated;
  logic              range_error;
  modport source (output valid, out_value, saturated, range_error, input ready);
  modport sink (input valid, out_value, saturated, range_error, output ready);
endinterface

// File: hdl/conv3x3_multiplane_leaky_relu_unit.sv
// An in-range compute transaction passes the memory read registers, the product register,
// the accumulator, the result register and the output register; an out-of-range one goes
// straight to the output register. The next transaction is taken once the result is loaded,
// later while a waiting result blocks the output register; a load keeps the unit ready.
// Reset clears control and configuration registers; the memories are not cleared.
// The output register lets the next transaction enter while a result waits.
module conv3x3_multiplane_leaky_relu_unit #(
  parameter int KERNEL_SIZE    = c3lr_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_IN_PLANES  = c3lr_pkg::MAX_IN_PLANES_DEF,
  parameter int MAX_OUT_PLANES = c3lr_pkg::MAX_OUT_PLANES_DEF,
  parameter int MAX_DIM        = c3lr_pkg::MAX_DIM_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  c3lr_in_if.sink                          in_s,
  c3lr_out_if.source                       out_s,
  input  logic                             cfg_we_i,
  input  logic [c3lr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [c3lr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import c3lr_pkg::*;

  localparam int WD   = MAX_OUT_PLANES * MAX_IN_PLANES * KERNEL_SIZE * KERNEL_SIZE;
  localparam int PD   = MAX_IN_PLANES * MAX_DIM * MAX_DIM;
  localparam int WAW  = (WD > 1) ? $clog2(WD) : 1;
  localparam int PAW  = (PD > 1) ? $clog2(PD) : 1;
  localparam int BAW  = (MAX_OUT_PLANES > 1) ? $clog2(MAX_OUT_PLANES) : 1;
  localparam int IPW  = (MAX_IN_PLANES > 1) ? $clog2(MAX_IN_PLANES) : 1;
  localparam int KW   = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int NIW  = $clog2(MAX_IN_PLANES + 1);
  localparam int NOW  = $clog2(MAX_OUT_PLANES + 1);
  localparam int ACC_W = 33 + $clog2(MAX_IN_PLANES * KERNEL_SIZE * KERNEL_SIZE + 1);

  state_e state_q, state_d;

  logic [6:0] width_q, height_q;
  logic [5:0] nin_q, nout_q;
  logic [DW-1:0]  w_eff, h_eff;
  logic [NIW-1:0] nin_eff;
  logic [NOW-1:0] nout_eff;

  logic [4:0] op_q;
  logic [5:0] row_q, col_q;
  logic [IPW-1:0] p_q;
  logic [KW-1:0]  i_q, j_q;
  logic first_q, v1_q, v2_q, last;

  logic in_acc, is_load, out_rng;
  mem_ctl_t mem_ctl;
  mac_ctl_t mac_ctl;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic signed [15:0] w_rdata, p_rdata, b_rdata, act;
  logic mac_sat;

  logic out_valid_q, out_sat_q, out_rerr_q, rerr_q;
  logic signed [15:0] out_value_q;
  logic out_load;

  int r_i, c_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'd64;
      height_q <= 7'd64;
      nin_q    <= 6'd1;
      nout_q   <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_NIN:    nin_q    <= cfg_data_i[5:0];
        CFG_NOUT:   nout_q   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff    = (width_q == '0) ? DW'(1) :
               ((32'(width_q) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(width_q));
    h_eff    = (height_q == '0) ? DW'(1) :
               ((32'(height_q) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(height_q));
    nin_eff  = (nin_q == '0) ? NIW'(1) :
               ((32'(nin_q) > 32'(MAX_IN_PLANES)) ? NIW'(MAX_IN_PLANES) : NIW'(nin_q));
    nout_eff = (nout_q == '0) ? NOW'(1) :
               ((32'(nout_q) > 32'(MAX_OUT_PLANES)) ? NOW'(MAX_OUT_PLANES) : NOW'(nout_q));
  end

  assign in_s.ready = (state_q == ST_IDLE);
  assign in_acc     = in_s.valid && in_s.ready;
  assign is_load    = in_acc && (kind_e'(in_s.kind) != KIND_COMPUTE);
  assign out_rng    = (32'(in_s.out_plane) >= 32'(nout_eff)) ||
                      (32'(in_s.row) >= 32'(h_eff)) || (32'(in_s.col) >= 32'(w_eff));

  always_comb begin
    mem_ctl.wgt_we  = is_load && (kind_e'(in_s.kind) == KIND_WEIGHT) &&
                      (32'(in_s.out_plane) < 32'(MAX_OUT_PLANES)) &&
                      (32'(in_s.in_plane) < 32'(MAX_IN_PLANES)) &&
                      (32'(in_s.row) < 32'(KERNEL_SIZE)) && (32'(in_s.col) < 32'(KERNEL_SIZE));
    mem_ctl.bias_we = is_load && (kind_e'(in_s.kind) == KIND_BIAS) &&
                      (32'(in_s.out_plane) < 32'(MAX_OUT_PLANES));
    mem_ctl.pix_we  = is_load && (kind_e'(in_s.kind) == KIND_PIXEL) &&
                      (32'(in_s.in_plane) < 32'(MAX_IN_PLANES)) &&
                      (32'(in_s.row) < 32'(MAX_DIM)) && (32'(in_s.col) < 32'(MAX_DIM));
    mem_ctl.bias_re = in_acc && (kind_e'(in_s.kind) == KIND_COMPUTE);
    mem_ctl.rd_en   = (state_q == ST_RUN);
  end

  assign w_waddr = WAW'(((32'(in_s.out_plane) * MAX_IN_PLANES + 32'(in_s.in_plane))
                         * KERNEL_SIZE + 32'(in_s.row)) * KERNEL_SIZE + 32'(in_s.col));
  assign p_waddr = PAW'((32'(in_s.in_plane) * MAX_DIM + 32'(in_s.row)) * MAX_DIM
                        + 32'(in_s.col));

  always_comb begin
    r_i = 32'(row_q) + 32'(i_q) - KERNEL_SIZE / 2;
    c_i = 32'(col_q) + 32'(j_q) - KERNEL_SIZE / 2;
    if (r_i < 0) begin
      r_i = 0;
    end
    if (r_i > 32'(h_eff) - 1) begin
      r_i = 32'(h_eff) - 1;
    end
    if (c_i < 0) begin
      c_i = 0;
    end
    if (c_i > 32'(w_eff) - 1) begin
      c_i = 32'(w_eff) - 1;
    end
  end

  assign w_raddr = WAW'(((32'(op_q) * MAX_IN_PLANES + 32'(p_q)) * KERNEL_SIZE + 32'(i_q))
                        * KERNEL_SIZE + 32'(j_q));
  assign p_raddr = PAW'((32'(p_q) * MAX_DIM + r_i) * MAX_DIM + c_i);
  assign last    = (32'(p_q) == 32'(nin_eff) - 1) && (32'(i_q) == KERNEL_SIZE - 1) &&
                   (32'(j_q) == KERNEL_SIZE - 1);

  assign out_load = (state_q == ST_ACT) && (!out_valid_q || out_s.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (kind_e'(in_s.kind) == KIND_COMPUTE)) begin
          state_d = out_rng ? ST_ACT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = ST_ACT;
        end
      end
      ST_ACT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mac_ctl.init   = (state_q == ST_RUN) && first_q;
    mac_ctl.mul_en = v1_q;
    mac_ctl.acc_en = v2_q;
    mac_ctl.fin_en = (state_q == ST_DRAIN) && !v1_q && !v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == ST_RUN);
      v2_q    <= v1_q;
      if (mem_ctl.bias_re) begin
        first_q <= 1'b1;
      end else if (state_q == ST_RUN) begin
        first_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_ctl.bias_re) begin
      op_q   <= in_s.out_plane;
      row_q  <= in_s.row;
      col_q  <= in_s.col;
      rerr_q <= out_rng;
      p_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
    end else if (state_q == ST_RUN) begin
      if (32'(j_q) == KERNEL_SIZE - 1) begin
        j_q <= '0;
        if (32'(i_q) == KERNEL_SIZE - 1) begin
          i_q <= '0;
          p_q <= p_q + 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end else begin
        j_q <= j_q + 1'b1;
      end
    end
    if (out_load) begin
      out_value_q <= rerr_q ? 16'sd0 : act;
      out_sat_q   <= rerr_q ? 1'b0 : mac_sat;
      out_rerr_q  <= rerr_q;
    end
  end

  assign out_s.valid       = out_valid_q;
  assign out_s.out_value   = out_value_q;
  assign out_s.saturated   = out_sat_q;
  assign out_s.range_error = out_rerr_q;

  c3lr_store #(
    .WAW (WAW),
    .PAW (PAW),
    .BAW (BAW)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .w_waddr_i (w_waddr),
    .w_raddr_i (w_raddr),
    .p_waddr_i (p_waddr),
    .p_raddr_i (p_raddr),
    .b_addr_i  (BAW'(in_s.out_plane)),
    .wdata_i   (in_s.value),
    .w_rdata_o (w_rdata),
    .p_rdata_o (p_rdata),
    .b_rdata_o (b_rdata)
  );

  c3lr_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .bias_i (b_rdata),
    .w_i    (w_rdata),
    .px_i   (p_rdata),
    .act_o  (act),
    .sat_o  (mac_sat)
  );

`ifndef SYNTHESIS
  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.bias_re && !out_rng) |=> (state_q == ST_RUN))
    else $error("in-range compute transaction did not start the MAC sequence");

  a_result_from_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_ACT))
    else $error("result register loaded outside the activation state");

  a_range_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rerr_q) |-> (out_value_q == 16'sd0 && !out_sat_q))
    else $error("range error result carries a nonzero value or saturation");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.fin_en |-> (!v1_q && !v2_q && !mem_ctl.rd_en))
    else $error("accumulator finished while products were still in flight");
`endif

endmodule

// File: hdl/c3lr_store.sv
// Weight, bias and pixel memories with registered read data.
module c3lr_store #(
  parameter int WAW = 14,
  parameter int PAW = 17,
  parameter int BAW = 5
) (
  input  logic                 clk_i,
  input  c3lr_pkg::mem_ctl_t   ctl_i,
  input  logic [WAW-1:0]       w_waddr_i,
  input  logic [WAW-1:0]       w_raddr_i,
  input  logic [PAW-1:0]       p_waddr_i,
  input  logic [PAW-1:0]       p_raddr_i,
  input  logic [BAW-1:0]       b_addr_i,
  input  logic signed [15:0]   wdata_i,
  output logic signed [15:0]   w_rdata_o,
  output logic signed [15:0]   p_rdata_o,
  output logic signed [15:0]   b_rdata_o
);
  import c3lr_pkg::*;

  logic signed [15:0] wmem [2**WAW];
  logic signed [15:0] pmem [2**PAW];
  logic signed [15:0] bmem [2**BAW];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wgt_we) begin
      wmem[w_waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      w_rdata_o <= wmem[w_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.pix_we) begin
      pmem[p_waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      p_rdata_o <= pmem[p_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.bias_we) begin
      bmem[b_addr_i] <= wdata_i;
    end
    if (ctl_i.bias_re) begin
      b_rdata_o <= bmem[b_addr_i];
    end
  end

endmodule

// File: hdl/c3lr_mac.sv
// Shared multiply-accumulate unit with rounding, saturation and leaky ReLU.
module c3lr_mac #(
  parameter int ACC_W = 42
) (
  input  logic                clk_i,
  input  c3lr_pkg::mac_ctl_t  ctl_i,
  input  logic signed [15:0]  bias_i,
  input  logic signed [15:0]  w_i,
  input  logic signed [15:0]  px_i,
  output logic signed [15:0]  act_o,
  output logic                sat_o
);
  import c3lr_pkg::*;

  logic signed [31:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] rnd;
  logic signed [15:0]      x_q;
  logic signed [15:0]      x_d;
  logic                    sat_q;
  logic                    sat_hi;
  logic                    sat_lo;
  logic signed [31:0]      slope;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= w_i * px_i;
    end
    if (ctl_i.init) begin
      acc_q <= {{(ACC_W-16){bias_i[15]}}, bias_i} <<< 12;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + {{(ACC_W-32){prod_q[31]}}, prod_q};
    end
    if (ctl_i.fin_en) begin
      x_q   <= x_d;
      sat_q <= sat_hi | sat_lo;
    end
  end

  always_comb begin
    rnd    = (acc_q + ACC_W'(2048)) >>> 12;
    sat_hi = !rnd[ACC_W-1] && (rnd[ACC_W-2:15] != '0);
    sat_lo = rnd[ACC_W-1] && (rnd[ACC_W-2:15] != '1);
    if (sat_hi) begin
      x_d = 16'sh7FFF;
    end else if (sat_lo) begin
      x_d = -16'sh8000;
    end else begin
      x_d = rnd[15:0];
    end
  end

  assign slope = 32'(x_q) * 32'(SLOPE_MUL);
  assign act_o = x_q[15] ? 16'(slope >>> 16) : x_q;
  assign sat_o = sat_q;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the 3x3 multi-plane convolution with leaky ReLU.
`timescale 1ns / 100ps

module tb_top;
  import c3lr_pkg::*;

  typedef struct {
    kind_e              kind;
    logic [4:0]         op;
    logic [4:0]         ip;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] val;
  } item_t;

  typedef struct {
    logic signed [15:0] value;
    logic               sat;
    logic               rerr;
  } pixel_res_t;

  typedef struct {
    item_t      it;
    bit         typed;
    pixel_res_t res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  c3lr_in_if  in_if ();
  c3lr_out_if out_if ();

  conv3x3_multiplane_leaky_relu_unit u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  logic signed [15:0] pix_mem [32][64][64];
  logic signed [15:0] wgt_mem [32][32][3][3];
  logic signed [15:0] bias_mem [32];
  bit pix_ok [32][64][64];
  bit wgt_ok [32][32][3][3];
  bit bias_ok [32];
  logic [6:0] width_reg, height_reg;
  logic [5:0] nin_reg, nout_reg;

  pixel_res_t pending_results[$];
  dir_row_t   dir_rows[$];
  int errors = 0;
  int items_sent = 0;
  int computes_sent = 0;
  int results_seen = 0;
  bit quiet = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int act_w();
    return clampi(int'(width_reg), 1, 64);
  endfunction

  function automatic int act_h();
    return clampi(int'(height_reg), 1, 64);
  endfunction

  function automatic int act_nin();
    return clampi(int'(nin_reg), 1, 32);
  endfunction

  function automatic int act_nout();
    return clampi(int'(nout_reg), 1, 32);
  endfunction

  function automatic bit in_window(item_t it);
    return int'(it.op) < act_nout() && int'(it.row) < act_h() && int'(it.col) < act_w();
  endfunction

  function automatic pixel_res_t conv_predict(item_t it);
    pixel_res_t r;
    longint acc, x;
    int rr, cc;
    r.value = '0;
    r.sat = 1'b0;
    r.rerr = 1'b0;
    if (!in_window(it)) begin
      r.rerr = 1'b1;
      return r;
    end
    acc = longint'(bias_mem[it.op]) * 4096;
    for (int p = 0; p < act_nin(); p++) begin
      for (int i = 0; i < 3; i++) begin
        rr = clampi(int'(it.row) + i - 1, 0, act_h() - 1);
        for (int j = 0; j < 3; j++) begin
          cc = clampi(int'(it.col) + j - 1, 0, act_w() - 1);
          acc += longint'(wgt_mem[it.op][p][i][j]) * longint'(pix_mem[p][rr][cc]);
        end
      end
    end
    x = (acc + 2048) >>> 12;
    if (x > 32767) begin
      x = 32767;
      r.sat = 1'b1;
    end
    if (x < -32768) begin
      x = -32768;
      r.sat = 1'b1;
    end
    if (x < 0) x = (x * SLOPE_MUL) >>> 16;
    r.value = x[15:0];
    return r;
  endfunction

  function automatic void store_update(item_t it);
    case (it.kind)
      KIND_WEIGHT: if (it.row < 3 && it.col < 3) begin
        wgt_mem[it.op][it.ip][it.row][it.col] = it.val;
        wgt_ok[it.op][it.ip][it.row][it.col] = 1'b1;
      end
      KIND_BIAS: begin
        bias_mem[it.op] = it.val;
        bias_ok[it.op] = 1'b1;
      end
      KIND_PIXEL: begin
        pix_mem[it.ip][it.row][it.col] = it.val;
        pix_ok[it.ip][it.row][it.col] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'sh7fff;
    if (sel == 1) return -16'sh8000;
    if (sel < 6) return 16'($urandom_range(0, 8191) - 4096);
    return 16'($urandom());
  endfunction

  function automatic item_t mk(kind_e k, int op, int ip, int row, int col, int val);
    item_t it;
    it.kind = k;
    it.op = 5'(op);
    it.ip = 5'(ip);
    it.row = 6'(row);
    it.col = 6'(col);
    it.val = 16'(val);
    return it;
  endfunction

  function automatic void add_row(item_t it, bit typed, int v, bit sat, bit rerr);
    dir_row_t d;
    d.it = it;
    d.typed = typed;
    d.res.value = 16'(v);
    d.res.sat = sat;
    d.res.rerr = rerr;
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  task automatic send_item(item_t it, bit typed, pixel_res_t typed_res);
    pixel_res_t exp_res;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 99) < 33) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.kind = it.kind;
    in_if.out_plane = it.op;
    in_if.in_plane = it.ip;
    in_if.row = it.row;
    in_if.col = it.col;
    in_if.value = it.val;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (it.kind == KIND_COMPUTE) begin
      computes_sent++;
      exp_res = typed ? typed_res : conv_predict(it);
      pending_results.insert(pending_results.size(), exp_res);
    end else begin
      store_update(it);
    end
  endtask

  task automatic send_plain(item_t it);
    pixel_res_t none;
    none = '{default: '0};
    send_item(it, 1'b0, none);
  endtask

  // Loads every store entry that the computation at this pixel reads and that is still unset.
  task automatic fill_window(item_t it);
    int rr, cc;
    if (!bias_ok[it.op]) send_plain(mk(KIND_BIAS, it.op, $urandom(), $urandom(),
                                       $urandom(), rand_value()));
    for (int p = 0; p < act_nin(); p++) begin
      for (int i = 0; i < 3; i++) begin
        rr = clampi(int'(it.row) + i - 1, 0, act_h() - 1);
        for (int j = 0; j < 3; j++) begin
          cc = clampi(int'(it.col) + j - 1, 0, act_w() - 1);
          if (!wgt_ok[it.op][p][i][j])
            send_plain(mk(KIND_WEIGHT, it.op, p, i, j, rand_value()));
          if (!pix_ok[p][rr][cc])
            send_plain(mk(KIND_PIXEL, $urandom(), p, rr, cc, rand_value()));
        end
      end
    end
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [6:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    case (idx)
      CFG_WIDTH:  width_reg = data;
      CFG_HEIGHT: height_reg = data;
      CFG_NIN:    nin_reg = data[5:0];
      CFG_NOUT:   nout_reg = data[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_config(int w, int h, int nin, int nout);
    cfg_write(CFG_WIDTH, 7'(w));
    cfg_write(CFG_HEIGHT, 7'(h));
    cfg_write(CFG_NIN, 7'(nin));
    cfg_write(CFG_NOUT, 7'(nout));
  endtask

  task automatic random_phase(int count);
    item_t it;
    int sel, start;
    start = items_sent;
    while (items_sent - start < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        it = mk(KIND_COMPUTE, $urandom_range(0, act_nout() - 1), $urandom(),
                $urandom_range(0, act_h() - 1), $urandom_range(0, act_w() - 1), $urandom());
      end else if (sel < 55) begin
        it = mk(KIND_COMPUTE, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else if (sel < 75) begin
        case ($urandom_range(0, 2))
          0: it = mk(KIND_WEIGHT, $urandom_range(0, act_nout() - 1),
                     $urandom_range(0, act_nin() - 1), $urandom_range(0, 2),
                     $urandom_range(0, 2), rand_value());
          1: it = mk(KIND_BIAS, $urandom_range(0, act_nout() - 1), $urandom(),
                     $urandom(), $urandom(), rand_value());
          default: it = mk(KIND_PIXEL, $urandom(), $urandom_range(0, act_nin() - 1),
                           $urandom_range(0, act_h() - 1), $urandom_range(0, act_w() - 1),
                           rand_value());
        endcase
      end else begin
        it = mk(kind_e'($urandom_range(0, 2)), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom());
      end
      if (it.kind == KIND_COMPUTE && in_window(it)) fill_window(it);
      send_plain(it);
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= quiet || ($urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk_i) begin
    pixel_res_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d sat=%0b rerr=%0b", $time,
                 out_if.out_value, out_if.saturated, out_if.range_error);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_if.out_value !== exp_res.value || out_if.saturated !== exp_res.sat ||
            out_if.range_error !== exp_res.rerr) begin
          errors++;
          $display("%0t: mismatch expected value=%0d sat=%0b rerr=%0b, %s%0d sat=%0b rerr=%0b",
                   $time, exp_res.value, exp_res.sat, exp_res.rerr, "actual value=",
                   out_if.out_value, out_if.saturated, out_if.range_error);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int cfgs[8][4];
    in_if.valid = 1'b0;
    in_if.kind = KIND_WEIGHT;
    in_if.out_plane = '0;
    in_if.in_plane = '0;
    in_if.row = '0;
    in_if.col = '0;
    in_if.value = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WIDTH;
    cfg_data_i = '0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    nin_reg = 6'd1;
    nout_reg = 6'd32;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_config(2, 2, 1, 1);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        add_row(mk(KIND_WEIGHT, 0, 0, i, j, 32767), 0, 0, 0, 0);
    add_row(mk(KIND_BIAS, 0, 0, 0, 0, 32767), 0, 0, 0, 0);
    for (int i = 0; i < 4; i++)
      add_row(mk(KIND_PIXEL, 0, 0, i / 2, i % 2, 32767), 0, 0, 0, 0);
    add_row(mk(KIND_COMPUTE, 0, 0, 0, 0, 0), 1, 32767, 1, 0);
    add_row(mk(KIND_BIAS, 0, 0, 0, 0, -32768), 0, 0, 0, 0);
    for (int i = 0; i < 4; i++)
      add_row(mk(KIND_PIXEL, 0, 0, i / 2, i % 2, -32768), 0, 0, 0, 0);
    add_row(mk(KIND_COMPUTE, 0, 31, 1, 1, 0), 1, -3277, 1, 0);
    add_row(mk(KIND_COMPUTE, 0, 0, 2, 0, 0), 1, 0, 0, 1);
    add_row(mk(KIND_COMPUTE, 0, 0, 0, 63, 0), 1, 0, 0, 1);
    add_row(mk(KIND_COMPUTE, 31, 0, 0, 0, 0), 1, 0, 0, 1);
    add_row(mk(KIND_WEIGHT, 0, 0, 3, 0, 5), 0, 0, 0, 0);
    add_row(mk(KIND_WEIGHT, 0, 0, 0, 63, 7), 0, 0, 0, 0);
    add_row(mk(KIND_PIXEL, 31, 0, 1, 0, 4096), 0, 0, 0, 0);
    add_row(mk(KIND_BIAS, 0, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(mk(KIND_COMPUTE, 0, 0, 1, 0, 0), 0, 0, 0, 0);
    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);
    drain_and_settle();

    cfgs = '{'{64, 64, 1, 32}, '{2, 2, 32, 1}, '{0, 0, 0, 0}, '{127, 100, 7'h42, 63},
             '{5, 3, 3, 4}, '{64, 1, 2, 32}, '{1, 64, 1, 5}, '{7, 9, 4, 3}};
    for (int ph = 0; ph < 8; ph++) begin
      set_config(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3]);
      quiet = (ph == 4);
      random_phase(130);
      drain_and_settle();
    end
    quiet = 1'b0;

    $display("Sent %0d items (%0d computations) over 9 register settings; %0d results checked.",
             items_sent, computes_sent, results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
